// ===== hdl/mt4_pkg.sv =====
// Shared types, constants and helper functions for the 4x4 transform core.
// Used by mt4_root_div and matrix_transform_4x4_core; depends on nothing.
package mt4_pkg;

	// Number format and iteration counts
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int CORD_N       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

	// Stream payload widths
	localparam int IN_W  = 136;
	localparam int OUT_W = 40;

	// Operation codes
	localparam logic [1:0] OP_IDENT = 2'd0;
	localparam logic [1:0] OP_TRANS = 2'd1;
	localparam logic [1:0] OP_SCALE = 2'd2;
	localparam logic [1:0] OP_ROT   = 2'd3;

	// Datapath widths
	localparam int MW     = 34;   // multiplier operand width
	localparam int PW     = 2 * MW;
	localparam int ACC_W  = 50;
	localparam int MOD_W  = 34;
	localparam int RAD_W  = FRAC_BITS + 9;
	localparam int MOD_STEPS = 25 - FRAC_BITS;
	localparam int CNT_W  = 5;

	localparam logic signed [MW-1:0] ONE_FIX   = MW'(1) << FRAC_BITS;
	localparam logic signed [MW-1:0] Q30_ONE   = MW'(1) << 30;
	localparam logic signed [MW-1:0] DEG2RAD   = MW'(74961321);
	localparam logic signed [MW-1:0] CORD_INIT = MW'(34'h026DD3B6A);

	// Angle reduction constants
	localparam logic [MOD_W-1:0] FULL_ANG = MOD_W'(360) << FRAC_BITS;
	localparam logic [MOD_W-1:0] MOD_BIAS = FULL_ANG << (MOD_STEPS - 1);
	localparam logic signed [MOD_W:0] FULL_S = (MOD_W+1)'(360) << FRAC_BITS;
	localparam logic signed [MOD_W:0] HALF_S = (MOD_W+1)'(180) << FRAC_BITS;
	localparam logic signed [MOD_W:0] QTR_S  = (MOD_W+1)'(90) << FRAC_BITS;

	// Request and response of the root / divide unit
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} rd_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} rd_rsp_t;

	// Arctangent table in Q30
	function automatic logic signed [MW-1:0] atan_q30(input logic [CNT_W-1:0] idx);
		logic signed [MW-1:0] v;
		case (idx)
			5'd0:  v = MW'(34'h03243F6A8);
			5'd1:  v = MW'(34'h01DAC6705);
			5'd2:  v = MW'(34'h00FADBAFC);
			5'd3:  v = MW'(34'h007F56EA6);
			5'd4:  v = MW'(34'h003FEAB76);
			5'd5:  v = MW'(34'h001FFD55B);
			5'd6:  v = MW'(34'h000FFFAAA);
			5'd7:  v = MW'(34'h0007FFF55);
			5'd8:  v = MW'(34'h0003FFFEA);
			5'd9:  v = MW'(34'h0001FFFFD);
			5'd10: v = MW'(34'h0000FFFFF);
			5'd11: v = MW'(34'h00007FFFF);
			5'd12: v = MW'(34'h00003FFFF);
			5'd13: v = MW'(34'h00001FFFF);
			5'd14: v = MW'(34'h00000FFFF);
			5'd15: v = MW'(34'h000007FFF);
			5'd16: v = MW'(34'h000003FFF);
			5'd17: v = MW'(34'h000001FFF);
			5'd18: v = MW'(34'h000000FFF);
			5'd19: v = MW'(34'h0000007FF);
			5'd20: v = MW'(34'h0000003FF);
			5'd21: v = MW'(34'h0000001FF);
			5'd22: v = MW'(34'h0000000FF);
			5'd23: v = MW'(34'h00000007F);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Clamp a wide signed value to the 32-bit element range
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > ACC_W'(32'sh7FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < -ACC_W'(33'sh080000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== hdl/mt4_root_div.sv =====
// Iterative integer square root and restoring divider, one step per cycle.
// Depends on mt4_pkg for the request and response types.
module mt4_root_div import mt4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rd_req_t     req,
	input  logic [61:0] rad,   // radicand for the square root
	input  logic [30:0] num,   // divide computes (num << 30) / den
	input  logic [31:0] den,
	output rd_rsp_t     rsp
);

	logic              busy_q;
	logic              sqrt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [62:0]       work_q;
	logic [62:0]       res_q;
	logic [62:0]       bit_q;
	logic              done_q;

	// Square root step
	logic [62:0] sq_trial;
	logic        sq_ge;
	// Divide step
	logic [32:0] dv_p;
	logic        dv_ge;
	logic        last_step;

	assign sq_trial  = res_q + bit_q;
	assign sq_ge     = work_q >= sq_trial;
	assign dv_p      = {work_q[31:0], bit_q[30]};
	assign dv_ge     = dv_p >= {1'b0, den};
	assign last_step = sqrt_q ? (cnt_q == CNT_W'(31)) : (cnt_q == CNT_W'(30));

	// Sequencing of the shared work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sqrt_q <= req.is_sqrt;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, result and bit or dividend shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.is_sqrt) begin
				work_q <= {1'b0, rad};
				res_q  <= '0;
				bit_q  <= 63'(1) << 62;
			end else begin
				work_q <= 63'(num[30:1]);
				res_q  <= '0;
				bit_q  <= {32'b0, num[0], 30'b0};
			end
		end else if (busy_q) begin
			if (sqrt_q) begin
				work_q <= sq_ge ? (work_q - sq_trial) : work_q;
				res_q  <= sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
				bit_q  <= bit_q >> 2;
			end else begin
				work_q <= 63'(dv_ge ? (dv_p - {1'b0, den}) : dv_p);
				res_q  <= {res_q[61:0], dv_ge};
				bit_q  <= {bit_q[61:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q[31:0];

endmodule

// ===== hdl/matrix_transform_4x4_core.sv =====
// 4x4 modelview transform core: one Q16.16 matrix, a single shared multiplier
// under a sequencer, and a serial root/divide unit. Identity and zero-axis rotate go
// straight to output; scale and translate run the multiplier first, and rotate runs
// axis normalization, a root, three divides, 9 reduction steps, 16 CORDIC steps and
// 61 multiplies before the 16 elements go out. One request at a time; ready only
// when idle. Reset loads identity.
module matrix_transform_4x4_core import mt4_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// s_tdata: operation[1:0], angle_deg[33:2], arg_x[65:34], arg_y[97:66],
	// arg_z[129:98], zero fill [135:130]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// m_tdata: row_index[1:0], col_index[3:2], element[35:4], zero fill [39:36]
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EMIT  = 4'd1;
	localparam logic [3:0] S_TRANS = 4'd2;
	localparam logic [3:0] S_SCALE = 4'd3;
	localparam logic [3:0] S_NORM  = 4'd4;
	localparam logic [3:0] S_SQ    = 4'd5;
	localparam logic [3:0] S_SQRT  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_MOD   = 4'd8;
	localparam logic [3:0] S_FOLD  = 4'd9;
	localparam logic [3:0] S_RAD   = 4'd10;
	localparam logic [3:0] S_CORD  = 4'd11;
	localparam logic [3:0] S_RMAT  = 4'd12;
	localparam logic [3:0] S_SKEW  = 4'd13;
	localparam logic [3:0] S_MMUL  = 4'd14;
	localparam logic [3:0] S_WB    = 4'd15;

	logic [3:0]              state_q;
	logic [1:0]              i_q, j_q, k_q, ph_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [3:0]              eidx_q;

	logic signed [31:0]      mat_q [16];
	logic signed [31:0]      v_q [3];
	logic [31:0]             a_q [3];
	logic [2:0]              neg_q;
	logic signed [MW-1:0]    u_q [3];
	logic [61:0]             sumsq_q;
	logic [31:0]             mag_q;
	logic [MOD_W-1:0]        mod_q;
	logic signed [RAD_W-1:0] ang_r_q;
	logic                    flip_q;
	logic signed [MW-1:0]    x_q, y_q, z_q, t_q;
	logic signed [MW-1:0]    rmat_q [3][3];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [35:0]      acc3_q [3];
	logic signed [PW-1:0]    prod_q;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic                    out_last_q;

	// Unpacked request fields
	logic [1:0]         in_op;
	logic signed [31:0] in_ang, in_x, in_y, in_z;
	assign in_op  = s_tdata[1:0];
	assign in_ang = s_tdata[33:2];
	assign in_x   = s_tdata[65:34];
	assign in_y   = s_tdata[97:66];
	assign in_z   = s_tdata[129:98];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Single matrix read port
	logic [3:0]         rd_addr;
	logic signed [31:0] m_rd;
	always_comb begin
		case (state_q)
			S_EMIT:  rd_addr = eidx_q;
			default: rd_addr = {k_q, j_q};
		endcase
	end
	assign m_rd = mat_q[rd_addr];

	// Rounded views of the product register
	localparam logic signed [PW-1:0] HALF_F = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] HALF_R = PW'(1) << (FRAC_BITS + 1);
	localparam logic signed [PW-1:0] HALF_Q = PW'(1) << 29;
	logic signed [PW-1:0] rnd_f, rnd_r, rnd_q;
	assign rnd_f = (prod_q + HALF_F) >>> FRAC_BITS;
	assign rnd_r = (prod_q + HALF_R) >>> (FRAC_BITS + 2);
	assign rnd_q = (prod_q + HALF_Q) >>> 30;

	// Operand selection for the shared multiplier
	logic signed [MW-1:0] mul_a, mul_b, omc, v_sel;
	assign omc = Q30_ONE - x_q;
	always_comb begin
		case (k_q)
			2'd0:    v_sel = MW'(v_q[0]);
			2'd1:    v_sel = MW'(v_q[1]);
			2'd2:    v_sel = MW'(v_q[2]);
			default: v_sel = ONE_FIX;
		endcase
	end
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TRANS, S_SCALE: begin
				mul_a = MW'(m_rd);
				mul_b = v_sel;
			end
			S_SQ: begin
				mul_a = signed'(MW'(a_q[k_q]));
				mul_b = signed'(MW'(a_q[k_q]));
			end
			S_RAD: begin
				mul_a = MW'(ang_r_q);
				mul_b = DEG2RAD;
			end
			S_RMAT: begin
				if (ph_q == 2'd0) begin
					mul_a = u_q[i_q];
					mul_b = u_q[j_q];
				end else begin
					mul_a = omc;
					mul_b = t_q;
				end
			end
			S_SKEW: begin
				mul_a = u_q[k_q];
				mul_b = y_q;
			end
			S_MMUL: begin
				mul_a = rmat_q[i_q][k_q];
				mul_b = MW'(m_rd);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Largest axis magnitude for normalization
	logic [31:0] a_max01, a_max;
	assign a_max01 = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
	assign a_max   = (a_q[2] > a_max01) ? a_q[2] : a_max01;

	// Angle reduction and folding
	logic [MOD_W-1:0]     mod_sub;
	logic [MOD_W:0]       mod_trial;
	logic signed [MOD_W:0] fold_a;
	assign mod_sub   = FULL_ANG << cnt_q;
	assign mod_trial = {1'b0, mod_q} - {1'b0, mod_sub};
	assign fold_a    = ({1'b0, mod_q} >= HALF_S) ? ({1'b0, mod_q} - FULL_S) : {1'b0, mod_q};

	// One CORDIC rotation step
	logic signed [MW-1:0] dx, dy, xn, yn, zn, atv;
	assign dx  = y_q >>> cnt_q;
	assign dy  = x_q >>> cnt_q;
	assign atv = atan_q30(cnt_q);
	assign xn  = z_q[MW-1] ? (x_q + dx) : (x_q - dx);
	assign yn  = z_q[MW-1] ? (y_q - dy) : (y_q + dy);
	assign zn  = z_q[MW-1] ? (z_q + atv) : (z_q - atv);

	// Root / divide unit
	rd_req_t rd_req;
	rd_rsp_t rd_rsp;
	assign rd_req.start   = ((state_q == S_SQRT) || (state_q == S_DIV)) && (ph_q == 2'd0);
	assign rd_req.is_sqrt = (state_q == S_SQRT);

	mt4_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.rad    (sumsq_q),
		.num    (a_q[k_q][30:0]),
		.den    (mag_q),
		.rsp    (rd_rsp)
	);

	// Sums used by the write-back paths
	logic signed [ACC_W-1:0] tr_sum;
	logic signed [MW-1:0]    rq34;
	assign tr_sum = acc_q + ACC_W'(rnd_f);
	assign rq34   = MW'(rnd_q);

	logic out_load;
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_tready);

	// Sequencer and matrix update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ph_q    <= '0;
			cnt_q   <= '0;
			eidx_q  <= '0;
			for (int e = 0; e < 16; e++)
				mat_q[e] <= (e % 5 == 0) ? 32'(ONE_FIX) : 32'sd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						i_q  <= '0;
						j_q  <= '0;
						k_q  <= '0;
						ph_q <= '0;
						case (in_op)
							OP_IDENT: begin
								for (int e = 0; e < 16; e++)
									mat_q[e] <= (e % 5 == 0) ? 32'(ONE_FIX) : 32'sd0;
								eidx_q  <= '0;
								state_q <= S_EMIT;
							end
							OP_TRANS: state_q <= S_TRANS;
							OP_SCALE: state_q <= S_SCALE;
							default: begin
								if (in_x == 32'sd0 && in_y == 32'sd0 && in_z == 32'sd0) begin
									eidx_q  <= '0;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_NORM;
								end
							end
						endcase
					end
				end

				S_TRANS: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (k_q == 2'd3) begin
							mat_q[{2'd3, j_q}] <= sat32(tr_sum);
							k_q <= '0;
							j_q <= j_q + 2'd1;
							if (j_q == 2'd3) begin
								eidx_q  <= '0;
								state_q <= S_EMIT;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end

				S_SCALE: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						mat_q[{k_q, j_q}] <= sat32(ACC_W'(rnd_f));
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3) begin
							k_q <= k_q + 2'd1;
							if (k_q == 2'd2) begin
								eidx_q  <= '0;
								state_q <= S_EMIT;
							end
						end
					end
				end

				S_NORM: begin
					if (a_max[31:30] == 2'b00 && a_max[29]) begin
						k_q     <= '0;
						state_q <= S_SQ;
					end
				end

				S_SQ: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						k_q  <= k_q + 2'd1;
						if (k_q == 2'd2)
							state_q <= S_SQRT;
					end
				end

				S_SQRT: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (rd_rsp.done) begin
						ph_q    <= 2'd0;
						k_q     <= '0;
						state_q <= S_DIV;
					end
				end

				S_DIV: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (rd_rsp.done) begin
						ph_q <= 2'd0;
						k_q  <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							cnt_q   <= CNT_W'(MOD_STEPS - 1);
							state_q <= S_MOD;
						end
					end
				end

				S_MOD: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= S_FOLD;
				end

				S_FOLD: begin
					ph_q    <= 2'd0;
					state_q <= S_RAD;
				end

				S_RAD: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q    <= 2'd0;
						cnt_q   <= '0;
						state_q <= S_CORD;
					end
				end

				S_CORD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CORD_N - 1)) begin
						i_q     <= '0;
						j_q     <= '0;
						ph_q    <= '0;
						state_q <= S_RMAT;
					end
				end

				S_RMAT: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (i_q == 2'd2) begin
								k_q     <= '0;
								state_q <= S_SKEW;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end

				S_SKEW: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						k_q  <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							state_q <= S_MMUL;
						end
					end
				end

				S_MMUL: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							if (k_q == 2'd2) begin
								k_q     <= '0;
								state_q <= S_WB;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							i_q <= i_q + 2'd1;
						end
					end
				end

				S_WB: begin
					mat_q[{i_q, j_q}] <= sat32(ACC_W'(acc3_q[i_q]));
					if (i_q == 2'd2) begin
						i_q <= '0;
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3) begin
							eidx_q  <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MMUL;
						end
					end else begin
						i_q <= i_q + 2'd1;
					end
				end

				S_EMIT: begin
					if (out_load) begin
						eidx_q <= eidx_q + 4'd1;
						if (eidx_q == 4'd15)
							state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Rotate and accumulate datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				v_q[0] <= in_x;
				v_q[1] <= in_y;
				v_q[2] <= in_z;
				a_q[0] <= in_x[31] ? 32'(-in_x) : 32'(in_x);
				a_q[1] <= in_y[31] ? 32'(-in_y) : 32'(in_y);
				a_q[2] <= in_z[31] ? 32'(-in_z) : 32'(in_z);
				neg_q  <= {in_z[31], in_y[31], in_x[31]};
				mod_q  <= MOD_W'(in_ang) + MOD_BIAS;
				acc_q  <= '0;
				sumsq_q <= '0;
				for (int r = 0; r < 3; r++)
					acc3_q[r] <= '0;
			end
			S_TRANS: begin
				if (ph_q == 2'd1)
					acc_q <= (k_q == 2'd3) ? '0 : tr_sum;
			end
			S_NORM: begin
				if (a_max[31:30] != 2'b00) begin
					for (int r = 0; r < 3; r++)
						a_q[r] <= a_q[r] >> 1;
				end else if (!a_max[29]) begin
					for (int r = 0; r < 3; r++)
						a_q[r] <= a_q[r] << 1;
				end
			end
			S_SQ: begin
				if (ph_q == 2'd1)
					sumsq_q <= sumsq_q + prod_q[61:0];
			end
			S_SQRT: begin
				if (rd_rsp.done)
					mag_q <= rd_rsp.result;
			end
			S_DIV: begin
				if (ph_q == 2'd1 && rd_rsp.done)
					u_q[k_q] <= neg_q[k_q] ? -MW'(rd_rsp.result) : MW'(rd_rsp.result);
			end
			S_MOD: begin
				if (!mod_trial[MOD_W])
					mod_q <= mod_trial[MOD_W-1:0];
			end
			S_FOLD: begin
				if (fold_a > QTR_S) begin
					ang_r_q <= RAD_W'(fold_a - HALF_S);
					flip_q  <= 1'b1;
				end else if (fold_a < -QTR_S) begin
					ang_r_q <= RAD_W'(fold_a + HALF_S);
					flip_q  <= 1'b1;
				end else begin
					ang_r_q <= RAD_W'(fold_a);
					flip_q  <= 1'b0;
				end
			end
			S_RAD: begin
				if (ph_q == 2'd1) begin
					z_q <= MW'(rnd_r);
					x_q <= CORD_INIT;
					y_q <= '0;
				end
			end
			S_CORD: begin
				z_q <= zn;
				if (cnt_q == CNT_W'(CORD_N - 1) && flip_q) begin
					x_q <= -xn;
					y_q <= -yn;
				end else begin
					x_q <= xn;
					y_q <= yn;
				end
			end
			S_RMAT: begin
				if (ph_q == 2'd1)
					t_q <= rq34;
				else if (ph_q == 2'd3)
					rmat_q[i_q][j_q] <= (i_q == j_q) ? (rq34 + x_q) : rq34;
			end
			S_SKEW: begin
				if (ph_q == 2'd1) begin
					case (k_q)
						2'd0: begin
							rmat_q[1][2] <= rmat_q[1][2] - rq34;
							rmat_q[2][1] <= rmat_q[2][1] + rq34;
						end
						2'd1: begin
							rmat_q[0][2] <= rmat_q[0][2] + rq34;
							rmat_q[2][0] <= rmat_q[2][0] - rq34;
						end
						default: begin
							rmat_q[0][1] <= rmat_q[0][1] - rq34;
							rmat_q[1][0] <= rmat_q[1][0] + rq34;
						end
					endcase
				end
			end
			S_MMUL: begin
				if (ph_q == 2'd1)
					acc3_q[i_q] <= acc3_q[i_q] + 36'(rnd_q);
			end
			S_WB: begin
				acc3_q[i_q] <= '0;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register: one element at a time, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'b0, m_rd, eidx_q[1:0], eidx_q[3:2]};
			out_last_q <= (eidx_q == 4'd15);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sim/tb_matrix_transform_4x4_core.sv =====
// Testbench for matrix_transform_4x4_core: drives transform requests and checks
// every emitted matrix element against a fixed-point model kept in the bench.
// Depends on mt4_pkg and the core RTL only.
module tb_matrix_transform_4x4_core;
	import mt4_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int N_RANDOM        = 310;

	typedef struct packed {
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value;
		logic               last;
	} element_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] ang;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        has_known;
		logic [31:0] known_m00;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;

	matrix_transform_4x4_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Bench copy of the transform matrix and the queue of elements still due.
	longint   model_mat[16];
	element_t pending_elements[$];
	int       error_count;
	int       idle_count;
	int       sent_count;
	int       elem_count;
	int       rot_count;
	int       send_idle_pct;
	int       recv_stall_pct;
	logic     hold_off;

	localparam longint ATAN_TAB[24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

	// Rounded shift: add half an LSB, then arithmetic shift (floors).
	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void reset_identity();
		for (int i = 0; i < 16; i++)
			model_mat[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
	endfunction

	// Angle reduction and CORDIC sine/cosine in Q30.
	function automatic void sine_cosine(longint ang, output longint sn, output longint cs);
		longint full, half, quarter, r, x, y, z, dx, dy;
		logic flip;
		full = 64'sd360 <<< FRAC_BITS;
		half = 64'sd180 <<< FRAC_BITS;
		quarter = 64'sd90 <<< FRAC_BITS;
		flip = 1'b0;
		r = ang % full;
		if (r < 0)
			r += full;
		if (r >= half)
			r -= full;
		if (r > quarter) begin
			r -= half;
			flip = 1'b1;
		end else if (r < -quarter) begin
			r += half;
			flip = 1'b1;
		end
		z = round_shift(r * 64'sd74961321, FRAC_BITS + 2);
		x = 64'sh26DD3B6A;
		y = 0;
		for (int i = 0; i < CORD_N; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TAB[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TAB[i];
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic void rotate_matrix(longint ang, longint vx, longint vy, longint vz);
		longint unsigned mag_v[3], mx, root;
		longint sg[3], unit[3], rm[3][3], sn, cs, omc, acc, nm[12], xs, ys, zs;
		sg[0] = vx;
		sg[1] = vy;
		sg[2] = vz;
		for (int i = 0; i < 3; i++)
			mag_v[i] = (sg[i] < 0) ? -sg[i] : sg[i];
		mx = (mag_v[0] > mag_v[1]) ? mag_v[0] : mag_v[1];
		if (mag_v[2] > mx)
			mx = mag_v[2];
		// A zero-length axis leaves the matrix untouched.
		if (mx == 0)
			return;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				mag_v[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				mag_v[i] <<= 1;
		end
		root = int_sqrt(mag_v[0] * mag_v[0] + mag_v[1] * mag_v[1] + mag_v[2] * mag_v[2]);
		for (int i = 0; i < 3; i++) begin
			unit[i] = longint'((mag_v[i] << 30) / root);
			if (sg[i] < 0)
				unit[i] = -unit[i];
		end
		sine_cosine(ang, sn, cs);
		omc = (64'sd1 <<< 30) - cs;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				rm[i][j] = round_shift(omc * round_shift(unit[i] * unit[j], 30), 30);
		for (int i = 0; i < 3; i++)
			rm[i][i] += cs;
		xs = round_shift(unit[0] * sn, 30);
		ys = round_shift(unit[1] * sn, 30);
		zs = round_shift(unit[2] * sn, 30);
		rm[0][1] -= zs;
		rm[1][0] += zs;
		rm[0][2] += ys;
		rm[2][0] -= ys;
		rm[1][2] -= xs;
		rm[2][1] += xs;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += round_shift(rm[i][k] * model_mat[k * 4 + j], 30);
				nm[i * 4 + j] = acc;
			end
		for (int i = 0; i < 12; i++)
			model_mat[i] = clamp32(nm[i]);
	endfunction

	// Apply one request to the bench matrix and queue the 16 elements it emits.
	function automatic void apply_transform(logic [1:0] op, logic [31:0] ang,
		logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
		longint v[3], acc;
		element_t e;
		v[0] = longint'($signed(ax));
		v[1] = longint'($signed(ay));
		v[2] = longint'($signed(az));
		case (op)
			OP_IDENT: reset_identity();
			OP_TRANS: begin
				for (int j = 0; j < 4; j++) begin
					acc = model_mat[12 + j];
					for (int k = 0; k < 3; k++)
						acc += round_shift(model_mat[k * 4 + j] * v[k], FRAC_BITS);
					model_mat[12 + j] = clamp32(acc);
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 4; j++)
						model_mat[i * 4 + j] =
							clamp32(round_shift(model_mat[i * 4 + j] * v[i], FRAC_BITS));
			end
			default: rotate_matrix(longint'($signed(ang)), v[0], v[1], v[2]);
		endcase
		for (int k = 0; k < 16; k++) begin
			e.row = k[3:2];
			e.col = k[1:0];
			e.value = model_mat[k][31:0];
			e.last = (k == 15);
			pending_elements.push_back(e);
		end
	endfunction

	// Clock and the single reset at start.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random stalls, plus a long hold-off while the sender keeps offering.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Output checker.
	always @(posedge clk) begin
		element_t got, want;
		if (m_tvalid && m_tready) begin
			got = element_t'({m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast});
			elem_count++;
			if (pending_elements.size() == 0) begin
				$display("%0t: unexpected element row %0d col %0d value %0d",
					$time, got.row, got.col, got.value);
				error_count++;
			end else begin
				want = pending_elements.pop_front();
				if (got.row !== want.row || got.col !== want.col ||
					got.value !== want.value || got.last !== want.last) begin
					$display("%0t: mismatch expected r%0d c%0d v%0d last%0d, got r%0d c%0d v%0d last%0d",
						$time, want.row, want.col, want.value, want.last,
						got.row, got.col, got.value, got.last);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request or element.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_CYCLES) begin
			$display("watchdog expired after %0d idle cycles", idle_count);
			$display("tb_matrix_transform_4x4_core NOT OK");
			$finish;
		end
	end

	// Offer one request, honoring the sender idle rate, and wait for acceptance.
	task automatic send_request(logic [1:0] op, logic [31:0] ang,
		logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, az, ay, ax, ang, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_transform(op, ang, ax, ay, az);
		sent_count++;
		if (op == OP_ROT)
			rot_count++;
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
			2: return 32'(($urandom_range(4) - 2) << FRAC_BITS);
			3: return 32'($signed($urandom_range(2 << FRAC_BITS)) - (1 << FRAC_BITS));
			4: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(720)) - 360) << FRAC_BITS;
		endcase
	endfunction

	initial begin
		stim_row_t table_rows[$];
		stim_row_t r;
		logic [1:0] op;
		logic [31:0] ax, ay, az;
		error_count = 0;
		idle_count = 0;
		sent_count = 0;
		elem_count = 0;
		rot_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		reset_identity();
		// Directed rows: op, angle, x, y, z, known flag, known element [0][0].
		table_rows = '{
			'{OP_IDENT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h00010000},
			'{OP_SCALE, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1, 32'h7FFFFFFF},
			'{OP_SCALE, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
			'{OP_TRANS, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
			'{OP_TRANS, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 32'h7FFFFFFF},
			'{OP_IDENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00010000},
			// Zero-length axis leaves the identity alone.
			'{OP_ROT, 32'h005A0000, 32'h0, 32'h0, 32'h0, 1'b1, 32'h00010000},
			'{OP_ROT, 32'h005A0000, 32'h0, 32'h0, 32'h00010000, 1'b0, 32'h0},
			'{OP_ROT, 32'hFFA60000, 32'h0, 32'h0, 32'h00010000, 1'b0, 32'h0},
			'{OP_ROT, 32'h00B40000, 32'h00010000, 32'h0, 32'h0, 1'b0, 32'h0},
			'{OP_ROT, 32'hFF4C0000, 32'h0, 32'hFFFF0000, 32'h0, 1'b0, 32'h0},
			'{OP_ROT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'h0},
			'{OP_ROT, 32'h80000000, 32'h00000001, 32'h00000001, 32'h00000001, 1'b0, 32'h0},
			'{OP_ROT, 32'h01680000, 32'h00030000, 32'h00040000, 32'h0, 1'b0, 32'h0},
			'{OP_ROT, 32'h00878000, 32'hFFFE0000, 32'h00010000, 32'h00050000, 1'b0, 32'h0},
			'{OP_TRANS, 32'h0, 32'h00028000, 32'hFFFF0000, 32'h00008000, 1'b0, 32'h0},
			'{OP_SCALE, 32'h0, 32'h00008000, 32'hFFFE0000, 32'h00000001, 1'b0, 32'h0},
			'{OP_ROT, 32'h001E0000, 32'h00010000, 32'h00010000, 32'h00010000, 1'b0, 32'h0},
			'{OP_IDENT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h00010000}
		};
		@(posedge arst_n);
		@(posedge clk);

		// Directed part, no idling on either side.
		foreach (table_rows[i]) begin
			r = table_rows[i];
			send_request(r.op, r.ang, r.ax, r.ay, r.az);
			if (r.has_known && model_mat[0] != longint'($signed(r.known_m00))) begin
				$display("%0t: row %0d expected element 0 %0d, predicted %0d", $time, i,
					$signed(r.known_m00), model_mat[0]);
				error_count++;
			end
		end

		// Random part over the idling phases; the long receiver hold-off sits in
		// the first phase.
		for (int n = 0; n < N_RANDOM; n++) begin
			case (n / (N_RANDOM / 5))
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				3: begin send_idle_pct = 19; recv_stall_pct = 19; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (n == 10)
				fork
					begin
						hold_off = 1'b1;
						repeat (600) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			// Return to a sane matrix now and then so values stay away from saturation.
			op = ($urandom_range(9) == 0) ? OP_IDENT : 2'($urandom_range(3));
			ax = random_value();
			ay = random_value();
			az = random_value();
			if (op == OP_ROT && $urandom_range(15) == 0) begin
				ax = 0;
				ay = 0;
				az = 0;
			end
			send_request(op, random_value(), ax, ay, az);
		end
		s_tvalid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		while (pending_elements.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d transform requests (%0d rotations), checked %0d matrix elements.",
			sent_count, rot_count, elem_count);
		if (error_count == 0 && pending_elements.size() == 0)
			$display("tb_matrix_transform_4x4_core OK");
		else
			$display("tb_matrix_transform_4x4_core NOT OK");
		$finish;
	end

endmodule
